// File: src/dllm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dllm_pkg
// Types and codes shared by the doubly linked list manager.
// ----------------------------------------------------------------------------
package dllm_pkg;

    localparam int NODE_W = 6;
    localparam int REQ_W  = 4;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_AFTER  = 4'd0,
        REQ_INS_BEFORE = 4'd1,
        REQ_APPEND     = 4'd2,
        REQ_PREPEND    = 4'd3,
        REQ_REMOVE     = 4'd4,
        REQ_POP        = 4'd5,
        REQ_FIRST      = 4'd6,
        REQ_LAST       = 4'd7,
        REQ_NEXT       = 4'd8,
        REQ_PREV       = 4'd9
    } req_code_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP1,
        ST_STEP2
    } state_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [NODE_W-1:0] node_id;
        logic [NODE_W-1:0] anchor_node;
    } req_t;

    typedef struct packed {
        logic [NODE_W-1:0] result_node;
        logic              status;
    } rsp_t;

endpackage

// File: src/doubly_linked_list_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doubly_linked_list_manager
// Circular doubly linked list over a pool of node numbers, entry 0 is head.
// ----------------------------------------------------------------------------
// Usage:
//   An item (req) is taken at a rising edge with start high and busy low.
//   Every item gives exactly one result on rsp, marked by done for one cycle.
//   The receiver cannot stall; a result is never held back.
// Sequence:
//   Errors, first, last, pop on an empty list and unused codes: result in the
//   cycle after the item is taken, next item may follow at once.
//   next / prev: one synchronous link memory read, result given from ST_STEP1.
//   Inserts, append, prepend, remove, pop: the link memories have one write
//   port each, and the four link updates are written in ST_STEP1 and ST_STEP2
//   after the neighbour read; busy is high until the result is given.
// Reset:
//   After rst_n the link memories are cleared one entry a cycle, all
//   NODE_COUNT entries, with busy high. The head links are also kept in registers.
// ----------------------------------------------------------------------------
module doubly_linked_list_manager #(
    parameter int NODE_COUNT = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  dllm_pkg::req_t req,
    output logic           done,
    output dllm_pkg::rsp_t rsp
);

    localparam int IDX_W   = $clog2(NODE_COUNT);
    localparam int LUT_LEN = 2 ** dllm_pkg::NODE_W;

    // link memories
    logic [IDX_W-1:0] f_mem [0:NODE_COUNT-1];
    logic [IDX_W-1:0] b_mem [0:NODE_COUNT-1];

    // operand reduction modulo NODE_COUNT
    logic [IDX_W-1:0] clamp_lut [0:LUT_LEN-1];

    genvar gi;
    generate
        for (gi = 0; gi < LUT_LEN; gi++) begin : g_clamp
            assign clamp_lut[gi] = IDX_W'(gi % NODE_COUNT);
        end
    endgenerate

    dllm_pkg::state_t    state_reg, state_next;
    dllm_pkg::req_code_t op_reg, op_next;
    logic [IDX_W-1:0]    node_reg, node_next;
    logic [IDX_W-1:0]    anc_reg, anc_next;
    logic [IDX_W-1:0]    x_reg, x_next;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    logic [IDX_W-1:0]    head_f_reg, head_f_next;
    logic [IDX_W-1:0]    head_b_reg, head_b_next;
    logic                done_reg, done_next;
    dllm_pkg::rsp_t      rsp_reg, rsp_next;
    logic [IDX_W-1:0]    f_q_reg, b_q_reg;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             f_we, b_we;
    logic [IDX_W-1:0] f_waddr, f_wdata, b_waddr, b_wdata;

    dllm_pkg::req_code_t in_op;
    logic [IDX_W-1:0]    in_node, in_anc, eff_anc;
    logic                empty;

    assign in_op   = dllm_pkg::req_code_t'(req.req_type);
    assign in_node = clamp_lut[req.node_id];
    assign in_anc  = clamp_lut[req.anchor_node];
    assign empty   = (head_f_reg == '0);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        node_next   = node_reg;
        anc_next    = anc_reg;
        x_next      = x_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        rsp_next    = rsp_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        f_we        = 1'b0;
        b_we        = 1'b0;
        f_waddr     = '0;
        f_wdata     = '0;
        b_waddr     = '0;
        b_wdata     = '0;
        eff_anc     = '0;

        unique case (state_reg)
            dllm_pkg::ST_CLEAR:
            begin
                f_we    = 1'b1;
                b_we    = 1'b1;
                f_waddr = clr_reg;
                b_waddr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(NODE_COUNT - 1))
                begin
                    state_next = dllm_pkg::ST_IDLE;
                end
            end

            dllm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    op_next   = in_op;
                    node_next = in_node;
                    rsp_next  = '0;
                    unique case (in_op)
                        dllm_pkg::REQ_INS_AFTER, dllm_pkg::REQ_INS_BEFORE,
                        dllm_pkg::REQ_APPEND, dllm_pkg::REQ_PREPEND:
                        begin
                            priority case (in_op)
                                dllm_pkg::REQ_APPEND:  eff_anc = head_b_reg;
                                dllm_pkg::REQ_PREPEND: eff_anc = head_f_reg;
                                default:               eff_anc = in_anc;
                            endcase
                            if (empty)
                            begin
                                eff_anc = '0;
                            end
                            anc_next = eff_anc;
                            rd_addr  = eff_anc;
                            rd_en    = 1'b1;
                            if (in_node == '0 ||
                                ((in_op == dllm_pkg::REQ_INS_AFTER ||
                                  in_op == dllm_pkg::REQ_INS_BEFORE) && in_anc == '0))
                            begin
                                rsp_next.status = 1'b1;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                state_next = dllm_pkg::ST_STEP1;
                            end
                        end
                        dllm_pkg::REQ_REMOVE, dllm_pkg::REQ_NEXT, dllm_pkg::REQ_PREV:
                        begin
                            rd_addr = in_node;
                            rd_en   = 1'b1;
                            if (in_node == '0)
                            begin
                                rsp_next.status = 1'b1;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                state_next = dllm_pkg::ST_STEP1;
                            end
                        end
                        dllm_pkg::REQ_POP:
                        begin
                            node_next = head_b_reg;
                            rd_addr   = head_b_reg;
                            rd_en     = 1'b1;
                            if (empty)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = dllm_pkg::ST_STEP1;
                            end
                        end
                        dllm_pkg::REQ_FIRST:
                        begin
                            rsp_next.result_node = empty ? '0 :
                                                   dllm_pkg::NODE_W'(head_f_reg);
                            done_next = 1'b1;
                        end
                        dllm_pkg::REQ_LAST:
                        begin
                            rsp_next.result_node = empty ? '0 :
                                                   dllm_pkg::NODE_W'(head_b_reg);
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            dllm_pkg::ST_STEP1:
            begin
                unique case (op_reg)
                    dllm_pkg::REQ_INS_AFTER, dllm_pkg::REQ_APPEND:
                    begin
                        x_next  = f_q_reg;
                        f_we    = 1'b1;
                        f_waddr = node_reg;
                        f_wdata = f_q_reg;
                        b_we    = 1'b1;
                        b_waddr = node_reg;
                        b_wdata = anc_reg;
                        state_next = dllm_pkg::ST_STEP2;
                    end
                    dllm_pkg::REQ_INS_BEFORE, dllm_pkg::REQ_PREPEND:
                    begin
                        x_next  = b_q_reg;
                        f_we    = 1'b1;
                        f_waddr = node_reg;
                        f_wdata = anc_reg;
                        b_we    = 1'b1;
                        b_waddr = node_reg;
                        b_wdata = b_q_reg;
                        state_next = dllm_pkg::ST_STEP2;
                    end
                    dllm_pkg::REQ_REMOVE, dllm_pkg::REQ_POP:
                    begin
                        // left.fwd = right, right.bwd = left
                        f_we    = 1'b1;
                        f_waddr = b_q_reg;
                        f_wdata = f_q_reg;
                        b_we    = 1'b1;
                        b_waddr = f_q_reg;
                        b_wdata = b_q_reg;
                        state_next = dllm_pkg::ST_STEP2;
                    end
                    dllm_pkg::REQ_NEXT:
                    begin
                        rsp_next.result_node = (node_reg == head_b_reg) ? '0 :
                                               dllm_pkg::NODE_W'(f_q_reg);
                        done_next  = 1'b1;
                        state_next = dllm_pkg::ST_IDLE;
                    end
                    dllm_pkg::REQ_PREV:
                    begin
                        rsp_next.result_node = (node_reg == head_f_reg) ? '0 :
                                               dllm_pkg::NODE_W'(b_q_reg);
                        done_next  = 1'b1;
                        state_next = dllm_pkg::ST_IDLE;
                    end
                    default:
                    begin
                        state_next = dllm_pkg::ST_IDLE;
                    end
                endcase
            end

            dllm_pkg::ST_STEP2:
            begin
                unique case (op_reg)
                    dllm_pkg::REQ_INS_AFTER, dllm_pkg::REQ_APPEND:
                    begin
                        f_we    = 1'b1;
                        f_waddr = anc_reg;
                        f_wdata = node_reg;
                        b_we    = 1'b1;
                        b_waddr = x_reg;
                        b_wdata = node_reg;
                    end
                    dllm_pkg::REQ_INS_BEFORE, dllm_pkg::REQ_PREPEND:
                    begin
                        f_we    = 1'b1;
                        f_waddr = x_reg;
                        f_wdata = node_reg;
                        b_we    = 1'b1;
                        b_waddr = anc_reg;
                        b_wdata = node_reg;
                    end
                    dllm_pkg::REQ_REMOVE, dllm_pkg::REQ_POP:
                    begin
                        f_we    = 1'b1;
                        f_waddr = node_reg;
                        b_we    = 1'b1;
                        b_waddr = node_reg;
                    end
                    default:
                    begin
                        f_we = 1'b0;
                    end
                endcase
                if (op_reg == dllm_pkg::REQ_POP)
                begin
                    rsp_next.result_node = dllm_pkg::NODE_W'(node_reg);
                end
                done_next  = 1'b1;
                state_next = dllm_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = dllm_pkg::ST_CLEAR;
            end
        endcase

        head_f_next = (f_we && f_waddr == '0) ? f_wdata : head_f_reg;
        head_b_next = (b_we && b_waddr == '0) ? b_wdata : head_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dllm_pkg::ST_CLEAR;
            clr_reg    <= '0;
            head_f_reg <= '0;
            head_b_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            head_f_reg <= head_f_next;
            head_b_reg <= head_b_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        node_reg <= node_next;
        anc_reg  <= anc_next;
        x_reg    <= x_next;
        rsp_reg  <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            f_mem[f_waddr] <= f_wdata;
        end
        if (rd_en)
        begin
            f_q_reg <= f_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[b_waddr] <= b_wdata;
        end
        if (rd_en)
        begin
            b_q_reg <= b_mem[rd_addr];
        end
    end

    assign busy = (state_reg != dllm_pkg::ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
